// ===== rtl/ffa_pkg.sv =====
// ============================================================================
// ffa_pkg - shared types and constants for the first-fit heap allocator
// Heap geometry, tag encoding, command and status codes.
// ============================================================================
`default_nettype none

package ffa_pkg;

    // heap geometry
    localparam int HEAP_WORDS  = 16384;
    localparam int AW          = $clog2(HEAP_WORDS);
    localparam int WORD_W      = 32;
    localparam int BA_W        = 17;            // byte offsets up to 65536
    localparam int CFG_W       = 17;
    localparam int SIZE_W      = 16;
    localparam int ADDR_W      = 16;
    localparam int CAP_BYTES   = (HEAP_WORDS * 4 < 65536) ? HEAP_WORDS * 4 : 65536;

    // tag layout and block rules
    localparam int MIN_BLOCK   = 16;
    localparam int FIRST_BP    = 16;            // first block after the prologue
    localparam int INIT_CHUNK  = 4096;
    localparam bit INIT_FITS   = (FIRST_BP + INIT_CHUNK <= CAP_BYTES);
    localparam int PRO_TAG     = 9;             // 8 | allocated
    localparam int ALLOC_TAG   = 1;             // epilogue
    localparam int INIT_FTR_B  = FIRST_BP + INIT_CHUNK - 8;
    localparam int INIT_EPI_B  = FIRST_BP + INIT_CHUNK - 4;
    localparam int BRK_RST     = INIT_FITS ? FIRST_BP + INIT_CHUNK : FIRST_BP;

    // request codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // response status
    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_IGN = 2'd1,
        ST_OOM = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/ffa_if.sv =====
// ============================================================================
// ffa_if - request and response channels of the heap allocator
// Valid/ready channels; a request moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface ffa_req_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] block_addr;

    modport source (output valid, output cmd, output size_bytes, output block_addr,
                    input ready);
    modport sink   (input valid, input cmd, input size_bytes, input block_addr,
                    output ready);
endinterface

interface ffa_rsp_if;
    import ffa_pkg::*;
    logic              valid;
    logic              ready;
    t_status           status;
    logic [ADDR_W-1:0] payload_addr;

    modport source (output valid, output status, output payload_addr, input ready);
    modport sink   (input valid, input status, input payload_addr, output ready);
endinterface

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// ============================================================================
// first_fit_heap_allocator - boundary-tag heap with first-fit placement
// Allocates and frees blocks in a word memory holding header/footer tags.
// ============================================================================
//
//  channel   dir  handshake     payload
//  i_req     in   valid/ready   cmd, size_bytes, block_addr
//  o_rsp     out  valid/ready   status, payload_addr
//  i_cfg     in   write enable  chunk_bytes (17 bits)
//
//  A request is accepted, then the walk reads and checks the tag of each block,
//  then tags are written for a fit, a split, break growth (with merge and split)
//  or a free; ignored requests go straight to output.
//  After reset the initial heap tags are written, the chunk tags only if they fit.
//  One request is in work at a time; a finished response waits in the
//  output register while the next request is accepted.
//
`default_nettype none

module first_fit_heap_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ffa_pkg::CFG_W-1:0] i_cfg_data,
    ffa_req_if.sink                   i_req,
    ffa_rsp_if.source                 o_rsp
);
    import ffa_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_WRD, S_WCK, S_GROW, S_GLAT, S_TH, S_TF,
        S_GEPI, S_PLACE, S_PSPL, S_FRP, S_FRN, S_FMG, S_FM2, S_DONE
    } t_state;

    localparam logic [2:0]      INIT_LAST = INIT_FITS ? 3'd4 : 3'd2;
    localparam logic [BA_W+1:0] CAP_L     = (BA_W+2)'(CAP_BYTES);

    function automatic logic [AW-1:0] widx(input logic [BA_W-1:0] a);
        return AW'(a >> 2);
    endfunction

    function automatic logic [WORD_W-1:0] tag(input logic [BA_W-1:0] sz, input logic ab);
        return WORD_W'({sz[BA_W-1:1], ab});
    endfunction

    // registers
    t_state              r_state, n_state, r_ret, n_ret;
    logic [2:0]          r_icnt, n_icnt;
    logic [BA_W-1:0]     r_brk, n_brk;
    logic [CFG_W-1:0]    r_chunk, n_chunk;
    logic                r_cmd, n_cmd;
    logic [BA_W-1:0]     r_asize, n_asize;
    logic [ADDR_W-1:0]   r_target, n_target;
    logic [BA_W-1:0]     r_bp, n_bp, r_size, n_size, r_csize, n_csize;
    logic [BA_W-1:0]     r_tbp, n_tbp, r_tsz, n_tsz;
    logic                r_tab, n_tab;
    logic [WORD_W-1:0]   r_pw, n_pw;
    logic [BA_W-1:0]     r_mbp, n_mbp, r_msz, n_msz;
    logic                r_mrg, n_mrg;
    t_status             r_st, n_st;
    logic [ADDR_W-1:0]   r_res, n_res;
    logic                r_rsp_valid, n_rsp_valid;
    t_status             r_rsp_st, n_rsp_st;
    logic [ADDR_W-1:0]   r_rsp_pa, n_rsp_pa;

    // RAM port
    logic                w_we;
    logic [AW-1:0]       w_waddr, w_raddr;
    logic [WORD_W-1:0]   w_wdata, w_rdata;

    // decoded tag of the last read and request sizing
    logic [BA_W-1:0]     w_rs, w_ps, w_req_asize, w_ext, w_rem;
    logic                w_ra;
    logic [SIZE_W:0]     w_sz15;
    logic [15:0]         w_gwords;
    logic [BA_W:0]       w_gs;
    logic [BA_W+1:0]     w_gend;

    ffa_ram #(.WIDTH(WORD_W), .DEPTH(HEAP_WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rs   = {w_rdata[BA_W-1:3], 3'b000};
    assign w_ra   = w_rdata[0];
    assign w_ps   = {r_pw[BA_W-1:3], 3'b000};
    assign w_sz15 = {1'b0, i_req.size_bytes} + (SIZE_W+1)'(15);
    assign w_req_asize = (i_req.size_bytes <= SIZE_W'(8)) ? BA_W'(MIN_BLOCK)
                                                          : {w_sz15[SIZE_W:3], 3'b000};
    // growth: max(asize, chunk) in words, rounded to an even count
    assign w_ext    = (r_asize > r_chunk) ? r_asize : r_chunk;
    assign w_gwords = {1'b0, w_ext[BA_W-1:2]} + {15'b0, w_ext[2]};
    assign w_gs     = {w_gwords, 2'b00};
    assign w_gend   = {2'b00, r_brk} + {1'b0, w_gs};
    assign w_rem    = r_csize - r_asize;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp_st;
    assign o_rsp.payload_addr = r_rsp_pa;

    // sequencer
    always_comb begin
        n_state = r_state;   n_ret = r_ret;     n_icnt = r_icnt;   n_brk = r_brk;
        n_cmd = r_cmd;       n_asize = r_asize; n_target = r_target;
        n_bp = r_bp;         n_size = r_size;   n_csize = r_csize;
        n_tbp = r_tbp;       n_tsz = r_tsz;     n_tab = r_tab;     n_pw = r_pw;
        n_mbp = r_mbp;       n_msz = r_msz;     n_mrg = r_mrg;
        n_st = r_st;         n_res = r_res;
        n_rsp_valid = r_rsp_valid; n_rsp_st = r_rsp_st; n_rsp_pa = r_rsp_pa;
        n_chunk = i_cfg_we ? i_cfg_data : r_chunk;
        w_we = 1'b0; w_waddr = '0; w_wdata = '0; w_raddr = '0;

        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            // initial prologue, chunk and epilogue tags
            S_INIT: begin
                w_we = 1'b1;
                case (r_icnt)
                    3'd0: begin
                        w_waddr = widx(BA_W'(4));  w_wdata = WORD_W'(PRO_TAG);
                    end
                    3'd1: begin
                        w_waddr = widx(BA_W'(8));  w_wdata = WORD_W'(PRO_TAG);
                    end
                    3'd2: begin
                        w_waddr = widx(BA_W'(12));
                        w_wdata = INIT_FITS ? WORD_W'(INIT_CHUNK) : WORD_W'(ALLOC_TAG);
                    end
                    3'd3: begin
                        w_waddr = widx(BA_W'(INIT_FTR_B)); w_wdata = WORD_W'(INIT_CHUNK);
                    end
                    default: begin
                        w_waddr = widx(BA_W'(INIT_EPI_B)); w_wdata = WORD_W'(ALLOC_TAG);
                    end
                endcase
                n_icnt = r_icnt + 3'd1;
                if (r_icnt == INIT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd    = i_req.cmd;
                    n_asize  = w_req_asize;
                    n_target = i_req.block_addr;
                    n_bp     = BA_W'(FIRST_BP);
                    n_res    = '0;
                    if ((i_req.cmd == CMD_ALLOC && i_req.size_bytes == '0) ||
                        (i_req.cmd == CMD_FREE && i_req.block_addr == '0)) begin
                        n_st = ST_IGN; n_state = S_DONE;
                    end else begin
                        n_state = S_WRD;
                    end
                end
            end
            // walk: read header of the block at r_bp
            S_WRD: begin
                w_raddr = widx(r_bp - BA_W'(4));
                if (r_bp >= r_brk) begin
                    if (r_cmd == CMD_ALLOC) begin
                        n_state = S_GROW;
                    end else begin
                        n_st = ST_IGN; n_state = S_DONE;
                    end
                end else begin
                    n_state = S_WCK;
                end
            end
            S_WCK: begin
                if (w_rs == '0) begin
                    if (r_cmd == CMD_ALLOC) begin
                        n_state = S_GROW;
                    end else begin
                        n_st = ST_IGN; n_state = S_DONE;
                    end
                end else if (r_cmd == CMD_ALLOC) begin
                    if (!w_ra && r_asize <= w_rs) begin
                        n_csize = w_rs; n_state = S_PLACE;
                    end else begin
                        n_bp = r_bp + w_rs; n_state = S_WRD;
                    end
                end else if (r_bp == {1'b0, r_target}) begin
                    if (w_ra) begin
                        n_size = w_rs; n_state = S_FRP;
                    end else begin
                        n_st = ST_IGN; n_state = S_DONE;
                    end
                end else if (r_bp > {1'b0, r_target}) begin
                    n_st = ST_IGN; n_state = S_DONE;
                end else begin
                    n_bp = r_bp + w_rs; n_state = S_WRD;
                end
            end
            // extend the break; fetch footer of the last block
            S_GROW: begin
                w_raddr = widx(r_brk - BA_W'(8));
                if (w_gend > CAP_L) begin
                    n_st = ST_OOM; n_state = S_DONE;
                end else begin
                    n_bp = r_brk; n_size = w_gs[BA_W-1:0]; n_state = S_GLAT;
                end
            end
            S_GLAT: begin
                n_pw = w_rdata;
                n_tbp = r_bp; n_tsz = r_size; n_tab = 1'b0;
                n_ret = S_GEPI; n_state = S_TH;
            end
            // tag writer: header then footer, then return
            S_TH: begin
                w_we = 1'b1; w_waddr = widx(r_tbp - BA_W'(4)); w_wdata = tag(r_tsz, r_tab);
                n_state = S_TF;
            end
            S_TF: begin
                w_we = 1'b1;
                w_waddr = widx(r_tbp + r_tsz - BA_W'(8));
                w_wdata = tag(r_tsz, r_tab);
                n_state = r_ret;
            end
            // new epilogue, merge with a free last block
            S_GEPI: begin
                w_we = 1'b1;
                w_waddr = widx(r_bp + r_size - BA_W'(4));
                w_wdata = WORD_W'(ALLOC_TAG);
                n_brk = r_brk + r_size;
                if (r_pw[0]) begin
                    n_csize = r_size; n_state = S_PLACE;
                end else begin
                    n_bp = r_bp - w_ps; n_csize = r_size + w_ps;
                    n_tbp = r_bp - w_ps; n_tsz = r_size + w_ps; n_tab = 1'b0;
                    n_ret = S_PLACE; n_state = S_TH;
                end
            end
            // mark allocated, split when the remainder is a full block
            S_PLACE: begin
                n_st = ST_OK; n_res = r_bp[ADDR_W-1:0];
                n_tbp = r_bp; n_tab = 1'b1; n_state = S_TH;
                if (w_rem >= BA_W'(MIN_BLOCK)) begin
                    n_tsz = r_asize; n_ret = S_PSPL;
                end else begin
                    n_tsz = r_csize; n_ret = S_DONE;
                end
            end
            S_PSPL: begin
                n_tbp = r_bp + r_asize; n_tsz = w_rem; n_tab = 1'b0;
                n_ret = S_DONE; n_state = S_TH;
            end
            // free: read neighbor tags before rewriting
            S_FRP: begin
                w_raddr = widx(r_bp - BA_W'(8));
                n_state = S_FRN;
            end
            S_FRN: begin
                n_pw = w_rdata;
                w_raddr = widx(r_bp + r_size - BA_W'(4));
                n_state = S_FMG;
            end
            S_FMG: begin
                n_mrg = !(r_pw[0] && w_ra);
                n_mbp = r_pw[0] ? r_bp : r_bp - w_ps;
                n_msz = r_size + (w_ra ? '0 : w_rs) + (r_pw[0] ? '0 : w_ps);
                n_st = ST_OK; n_res = '0;
                n_tbp = r_bp; n_tsz = r_size; n_tab = 1'b0;
                n_ret = S_FM2; n_state = S_TH;
            end
            S_FM2: begin
                if (r_mrg) begin
                    n_tbp = r_mbp; n_tsz = r_msz; n_tab = 1'b0;
                    n_ret = S_DONE; n_state = S_TH;
                end else begin
                    n_state = S_DONE;
                end
            end
            // hand the response to the output register
            S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid = 1'b1; n_rsp_st = r_st; n_rsp_pa = r_res;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_ret       <= S_DONE;
            r_icnt      <= '0;
            r_brk       <= BA_W'(BRK_RST);
            r_chunk     <= CFG_W'(INIT_CHUNK);
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_icnt      <= n_icnt;
            r_brk       <= n_brk;
            r_chunk     <= n_chunk;
            r_rsp_valid <= n_rsp_valid;
        end
        r_cmd <= n_cmd;     r_asize <= n_asize; r_target <= n_target;
        r_bp <= n_bp;       r_size <= n_size;   r_csize <= n_csize;
        r_tbp <= n_tbp;     r_tsz <= n_tsz;     r_tab <= n_tab;   r_pw <= n_pw;
        r_mbp <= n_mbp;     r_msz <= n_msz;     r_mrg <= n_mrg;
        r_st <= n_st;       r_res <= n_res;
        r_rsp_st <= n_rsp_st; r_rsp_pa <= n_rsp_pa;
    end

`ifndef SYNTHESIS
    // break stays 8-byte aligned and inside capacity
    a_brk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_brk[2:0] == 3'b000 && {2'b00, r_brk} <= CAP_L)
        else $error("break misaligned or past capacity");

    // walk only reads tags inside the heap
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WCK |-> r_bp < r_brk && r_bp[2:0] == 3'b000)
        else $error("walk pointer outside heap");

    // granted payload offsets are aligned
    a_pa: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status == ST_OK && o_rsp.payload_addr != '0
        |-> o_rsp.payload_addr[2:0] == 3'b000)
        else $error("misaligned payload offset");
`endif

endmodule

`default_nettype wire

// ===== rtl/ffa_ram.sv =====
// ============================================================================
// ffa_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== tb/ffa_heap_checker.sv =====
// ============================================================================
// ffa_heap_checker - response checker for the first-fit heap allocator
// Mirrors the tagged heap, predicts the answer to every accepted request
// and compares it with the responses in order.
// ============================================================================
`default_nettype none

module ffa_heap_checker
    import ffa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    ffa_req_if               req,
    ffa_rsp_if               rsp,
    output int               o_errors,
    output int               o_pending,
    output int               o_responses
);

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] addr;
    } t_answer;

    // mirrored heap state
    logic [31:0] mem [HEAP_WORDS];
    int unsigned brk;
    int unsigned chunk;
    t_answer     answers_due [$];

    function automatic logic [31:0] rd(int unsigned a);
        return (a >> 2) < HEAP_WORDS ? mem[a >> 2] : 32'd0;
    endfunction

    function automatic void wr(int unsigned a, logic [31:0] v);
        if ((a >> 2) < HEAP_WORDS)
            mem[a >> 2] = v;
    endfunction

    function automatic int unsigned bsize(int unsigned bp);
        return rd(bp - 4) & 32'hFFFF_FFF8;
    endfunction

    function automatic void tag(int unsigned bp, int unsigned sz, bit al);
        wr(bp - 4, sz | al);
        wr(bp + sz - 8, sz | al);
    endfunction

    // four-way coalesce of a free block with its neighbors
    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned sz;
        int unsigned prev_tag;
        int unsigned nxt;
        bit          next_al;
        sz       = bsize(bp);
        prev_tag = rd(bp - 8);
        nxt      = bp + sz;
        next_al  = rd(nxt - 4) & 1;
        if (prev_tag[0] && next_al)
            return bp;
        if (!next_al)
            sz += bsize(nxt);
        if (!prev_tag[0]) begin
            sz += prev_tag & 32'hFFFF_FFF8;
            bp -= prev_tag & 32'hFFFF_FFF8;
        end
        tag(bp, sz, 0);
        return bp;
    endfunction

    // move the break; 0 when past capacity or smaller than a minimum block
    function automatic int unsigned extend(int unsigned bytes);
        int unsigned words;
        int unsigned sz;
        int unsigned bp;
        words = bytes >> 2;
        if (words & 1)
            words++;
        sz = words * 4;
        if (sz < MIN_BLOCK || brk + sz > CAP_BYTES)
            return 0;
        bp = brk;
        tag(bp, sz, 0);
        wr(bp + sz - 4, 1);
        brk += sz;
        return coalesce(bp);
    endfunction

    // first free fit, or the allocated block at target
    function automatic int unsigned find(bit want_free, int unsigned asz, int unsigned target);
        int unsigned bp;
        int unsigned s;
        bp = FIRST_BP;
        while (bp < brk) begin
            s = bsize(bp);
            if (s == 0)
                break;
            if (want_free) begin
                if (!(rd(bp - 4) & 1) && asz <= s)
                    return bp;
            end else if (bp == target) begin
                return (rd(bp - 4) & 1) ? bp : 0;
            end else if (bp > target) begin
                return 0;
            end
            bp += s;
        end
        return 0;
    endfunction

    function automatic t_answer serve(logic c, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
        t_answer     ans;
        int unsigned asz;
        int unsigned bp;
        int unsigned csz;
        ans = '{ST_OK, '0};
        if (c == CMD_ALLOC) begin
            if (sz == 0) begin
                ans.status = ST_IGN;
            end else begin
                asz = (sz <= 8) ? 16 : 8 * ((sz + 15) / 8);
                bp  = find(1, asz, 0);
                if (bp == 0)
                    bp = extend(asz > chunk ? asz : chunk);
                if (bp == 0) begin
                    ans.status = ST_OOM;
                end else begin
                    csz = bsize(bp);
                    if (csz - asz >= MIN_BLOCK) begin
                        tag(bp, asz, 1);
                        tag(bp + asz, csz - asz, 0);
                    end else begin
                        tag(bp, csz, 1);
                    end
                    ans.addr = bp[ADDR_W-1:0];
                end
            end
        end else begin
            bp = (a == 0) ? 0 : find(0, 0, a);
            if (bp == 0) begin
                ans.status = ST_IGN;
            end else begin
                tag(bp, bsize(bp), 0);
                void'(coalesce(bp));
            end
        end
        return ans;
    endfunction

    task automatic report(string what, t_answer got, t_answer want);
        o_errors++;
        $display("checker: %s got status %0d addr %0d, expected status %0d addr %0d",
                 what, got.status, got.addr, want.status, want.addr);
    endtask

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            foreach (mem[i]) mem[i] = '0;
            wr(4, PRO_TAG);
            wr(8, PRO_TAG);
            wr(12, ALLOC_TAG);
            brk   = FIRST_BP;
            chunk = INIT_CHUNK;
            void'(extend(chunk));
            answers_due.delete();
        end else begin
            // response side first: a response never belongs to this edge's request
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.status, rsp.payload_addr};
                if (answers_due.size() == 0) begin
                    report("unexpected response", got, got);
                end else begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status)
                        report("status mismatch", got, want);
                    else if (got.addr !== want.addr)
                        report("address mismatch", got, want);
                    o_responses++;
                end
            end
            if (req.valid && req.ready)
                answers_due.push_back(serve(req.cmd, req.size_bytes, req.block_addr));
            if (i_cfg_we)
                chunk = i_cfg_data;
        end
        o_pending <= answers_due.size();
    end

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_responses = 0;
    end

endmodule

`default_nettype wire

// ===== tb/first_fit_heap_allocator_tb.sv =====
// ============================================================================
// first_fit_heap_allocator_tb - testbench for the first-fit heap allocator
// Drives allocate and free requests with random stalls, sweeps the growth
// chunk register and lets the checker judge every response.
// ============================================================================
`default_nettype none

module first_fit_heap_allocator_tb;
    import ffa_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    int               errors;
    int               pending;
    int               responses;
    int               sent;
    bit               calm;
    logic [ADDR_W-1:0] live [$];

    ffa_req_if req ();
    ffa_rsp_if rsp ();

    first_fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_req(req.sink), .o_rsp(rsp.source)
    );

    ffa_heap_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .req(req), .rsp(rsp),
        .o_errors(errors), .o_pending(pending), .o_responses(responses)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // track allocated addresses for realistic frees
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.payload_addr != 0)
            live.push_back(rsp.payload_addr);
    end

    // response stall bursts
    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
        end
    end

    // valid stays high after acceptance; the next request or drain updates it
    task automatic send(logic c, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
        if (!calm && $urandom_range(0, 7) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        req.valid      <= 1'b1;
        req.cmd        <= c;
        req.size_bytes <= sz;
        req.block_addr <= a;
        do @(posedge i_clk); while (!req.ready);
        sent++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_chunk(logic [CFG_W-1:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        live.delete();
    endtask

    // random mix: mostly allocs and frees of live blocks, some noise
    task automatic random_phase(int n);
        int          r;
        int          k;
        logic [15:0] sz;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                sz = (r < 40) ? 16'($urandom_range(1, 300)) : 16'($urandom);
                send(CMD_ALLOC, sz, 16'($urandom));
            end else if (r < 85 && live.size() > 0) begin
                k = $urandom_range(0, live.size() - 1);
                send(CMD_FREE, 16'($urandom), live[k]);
                live.delete(k);
            end else if (r < 92) begin
                send(CMD_FREE, 16'($urandom), 16'($urandom));
            end else begin
                send(r[0] ? CMD_FREE : CMD_ALLOC, 16'($urandom), 16'd0);
            end
        end
    endtask

    initial begin
        req.valid = 1'b0;
        req.cmd = CMD_ALLOC;
        req.size_bytes = '0;
        req.block_addr = '0;
        sent = 0;
        calm = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, ignored cases, bad and double frees, growth
        send(CMD_ALLOC, 16'd0, 16'hFFFF);
        send(CMD_FREE, 16'hFFFF, 16'd0);
        send(CMD_ALLOC, 16'd1, 16'd0);
        send(CMD_ALLOC, 16'd8, 16'd0);
        send(CMD_ALLOC, 16'd9, 16'd0);
        send(CMD_ALLOC, 16'd4000, 16'd0);
        send(CMD_ALLOC, 16'hFFFF, 16'd0);
        send(CMD_FREE, 16'd0, 16'd16);
        send(CMD_FREE, 16'd0, 16'd16);
        send(CMD_FREE, 16'd0, 16'd20);
        send(CMD_FREE, 16'd0, 16'hFFFF);
        send(CMD_FREE, 16'd0, 16'd32);
        send(CMD_ALLOC, 16'd24, 16'd0);
        send(CMD_ALLOC, 16'd20000, 16'd0);
        send(CMD_ALLOC, 16'd40000, 16'd0);
        send(CMD_FREE, 16'd0, 16'd48);
        drain();

        // chunk sweep, extremes included
        set_chunk(17'd16);
        random_phase(250);
        set_chunk(17'd65536);
        send(CMD_ALLOC, 16'd100, 16'd0);
        random_phase(150);
        set_chunk(17'h1FFFF);
        send(CMD_ALLOC, 16'd16, 16'd0);
        random_phase(100);
        set_chunk(17'd100);
        random_phase(300);
        set_chunk(17'd4096);
        random_phase(150);
        calm = 1'b1;
        random_phase(200);

        drain();
        $display("run covered %0d requests and %0d responses over five chunk settings",
                 sent, responses);
        if (errors == 0)
            $display("first_fit_heap_allocator_tb: clean");
        else
            $display("first_fit_heap_allocator_tb: errors");
        $finish;
    end

    initial begin
        #1000000000;
        $display("first_fit_heap_allocator_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== first_fit_heap_allocator.f =====
rtl/ffa_pkg.sv
rtl/ffa_if.sv
rtl/ffa_ram.sv
rtl/first_fit_heap_allocator.sv
tb/ffa_heap_checker.sv
tb/first_fit_heap_allocator_tb.sv
